// ----- hdl/kvht_pkg.sv -----
// ----------------------------------------------------------------------------
// kvht_pkg
// Shared types and constants for the key/value hash table.
// ----------------------------------------------------------------------------
package kvht_pkg;
    localparam int MaxBuckets = 256;
    localparam int PoolNodes  = 1024;
    localparam int BktW  = $clog2(MaxBuckets);
    localparam int NodeW = $clog2(PoolNodes);
    localparam int LinkW = NodeW + 1;
    localparam int CntW  = 9;
    localparam logic [LinkW-1:0] Nil = LinkW'(PoolNodes);

    typedef enum logic [1:0] {
        K_PUT = 2'd0, K_GET = 2'd1, K_REMOVE = 2'd2, K_ANY = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_OK = 2'd0, S_NOT_FOUND = 2'd1, S_FULL = 2'd2, S_EMPTY = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DIV, ST_HEAD, ST_HEAD_W, ST_NODE, ST_NODE_W,
        ST_CHECK, ST_PUT_FREE, ST_PUT_FREE_W, ST_PUT_LINK, ST_RM_LINK,
        ST_RM_LINK_W, ST_RM_FIX, ST_ANY, ST_ANY_W, ST_ANY_KEY, ST_ANY_KEY_W,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic       start;
        logic [31:0] mag;
        logic [CntW-1:0] divisor;
    } t_div_req;
endpackage

// ----- hdl/kvht_if.sv -----
// ----------------------------------------------------------------------------
// kvht_in_if / kvht_out_if
// Valid/ready channels for request and result words.
// ----------------------------------------------------------------------------
interface kvht_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic signed [31:0] key;
    logic signed [31:0] value;
    modport source (output valid, kind, key, value, input ready);
    modport sink (input valid, kind, key, value, output ready);
endinterface

interface kvht_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic signed [31:0] value_out;
    logic signed [31:0] key_out;
    logic [10:0] entry_count;
    modport source (output valid, status, value_out, key_out, entry_count, input ready);
    modport sink (input valid, status, value_out, key_out, entry_count, output ready);
endinterface

// ----- hdl/key_value_hash_table.sv -----
// ----------------------------------------------------------------------------
// key_value_hash_table
// Separate-chaining hash map over a fixed node pool, walked by a sequencer.
// ----------------------------------------------------------------------------
//  channel  | dir | words
//  s_in     | in  | kind, key, value
//  m_out    | out | status, value_out, key_out, entry_count
//  cfg      | in  | bucket_count write
//
// a request first runs the key magnitude through the remainder unit, then
// walks the chain from the bucket head node by node; a put of a new key or a
// remove then relinks nodes. any-key also runs the remainder unit, then scans
// the buckets in order up to the first non-empty head; an empty table skips it.
// after reset or a bucket_count write, a clearing pass rebuilds the free list
// and bucket heads; no word is accepted meanwhile.
// ready is low from acceptance until the result word is taken.
module key_value_hash_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kvht_in_if.sink    s_in,
    kvht_out_if.source m_out,
    input  logic       i_cfg_we,
    input  logic [8:0] i_cfg_data
);
    localparam int BW = kvht_pkg::BktW;
    localparam int NW = kvht_pkg::NodeW;
    localparam int LW = kvht_pkg::LinkW;

    // memories
    logic [LW-1:0] r_heads [kvht_pkg::MaxBuckets];
    logic [31:0]   r_keys  [kvht_pkg::PoolNodes];
    logic [31:0]   r_vals  [kvht_pkg::PoolNodes];
    logic [LW-1:0] r_links [kvht_pkg::PoolNodes];

    kvht_pkg::t_state r_state, n_state;
    logic [8:0]    r_bcnt;
    logic [LW-1:0] r_free, r_total, r_cur, r_prev, r_nxt;
    logic [NW:0]   r_clr;
    logic [NW:0]   r_steps;
    logic [BW-1:0] r_bkt;
    logic [8:0]    r_scan;
    logic [1:0]    r_kind;
    logic [31:0]   r_key, r_val;
    logic [31:0]   r_rd_key, r_rd_val;
    logic [LW-1:0] r_rd_link, r_rd_head;
    logic [1:0]    r_status;
    logic [31:0]   r_vout, r_kout;

    kvht_pkg::t_div_req w_req;
    logic        w_div_done;
    logic [8:0]  w_rem;
    logic [8:0]  w_cfg;

    assign w_cfg = (i_cfg_data == 9'd0) ? 9'd1 :
                   (i_cfg_data > 9'(kvht_pkg::MaxBuckets)) ? 9'(kvht_pkg::MaxBuckets)
                                                           : i_cfg_data;
    assign w_req.start   = (r_state == kvht_pkg::ST_IDLE) && s_in.valid && !i_cfg_we;
    assign w_req.mag     = s_in.key[31] ? (32'd0 - s_in.key) : s_in.key;
    assign w_req.divisor = r_bcnt;

    kvht_div u_div (
        .i_clk  (i_clk), .i_rst_n(i_rst_n), .i_req(w_req),
        .o_done (w_div_done), .o_rem(w_rem)
    );

    assign s_in.ready        = w_req.start;
    assign m_out.valid       = (r_state == kvht_pkg::ST_DONE);
    assign m_out.status      = r_status;
    assign m_out.value_out   = r_vout;
    assign m_out.key_out     = r_kout;
    assign m_out.entry_count = r_total;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= kvht_pkg::ST_CLEAR;
        else          r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kvht_pkg::ST_CLEAR:
                if (r_clr == (NW+1)'(kvht_pkg::PoolNodes - 1)) n_state = kvht_pkg::ST_IDLE;
            kvht_pkg::ST_IDLE:
                if (w_req.start) n_state = kvht_pkg::ST_DIV;
            kvht_pkg::ST_DIV:
                if (w_div_done) n_state = (r_kind == kvht_pkg::K_ANY) ?
                    ((r_total == '0) ? kvht_pkg::ST_DONE : kvht_pkg::ST_ANY)
                    : kvht_pkg::ST_HEAD;
            kvht_pkg::ST_HEAD:   n_state = kvht_pkg::ST_HEAD_W;
            kvht_pkg::ST_HEAD_W: n_state = kvht_pkg::ST_NODE;
            kvht_pkg::ST_NODE:
                n_state = (r_cur >= kvht_pkg::Nil || r_steps[NW]) ? kvht_pkg::ST_CHECK
                                                                  : kvht_pkg::ST_NODE_W;
            kvht_pkg::ST_NODE_W:
                n_state = (r_rd_key == r_key) ? kvht_pkg::ST_CHECK : kvht_pkg::ST_NODE;
            kvht_pkg::ST_CHECK: begin
                n_state = kvht_pkg::ST_DONE;
                if (r_cur < kvht_pkg::Nil && r_rd_key == r_key && !r_steps[NW]) begin
                    if (r_kind == kvht_pkg::K_REMOVE) n_state = kvht_pkg::ST_RM_LINK;
                end else if (r_kind == kvht_pkg::K_PUT && r_free < kvht_pkg::Nil) begin
                    n_state = kvht_pkg::ST_PUT_FREE;
                end
            end
            kvht_pkg::ST_PUT_FREE:   n_state = kvht_pkg::ST_PUT_FREE_W;
            kvht_pkg::ST_PUT_FREE_W: n_state = kvht_pkg::ST_PUT_LINK;
            kvht_pkg::ST_PUT_LINK:   n_state = kvht_pkg::ST_DONE;
            kvht_pkg::ST_RM_LINK:    n_state = kvht_pkg::ST_RM_LINK_W;
            kvht_pkg::ST_RM_LINK_W:  n_state = kvht_pkg::ST_RM_FIX;
            kvht_pkg::ST_RM_FIX:     n_state = kvht_pkg::ST_DONE;
            kvht_pkg::ST_ANY:        n_state = kvht_pkg::ST_ANY_W;
            kvht_pkg::ST_ANY_W:
                if (r_rd_head < kvht_pkg::Nil) n_state = kvht_pkg::ST_ANY_KEY;
                else if (r_scan + 9'd1 >= r_bcnt) n_state = kvht_pkg::ST_DONE;
                else n_state = kvht_pkg::ST_ANY;
            kvht_pkg::ST_ANY_KEY:    n_state = kvht_pkg::ST_ANY_KEY_W;
            kvht_pkg::ST_ANY_KEY_W:  n_state = kvht_pkg::ST_DONE;
            kvht_pkg::ST_DONE:
                if (m_out.ready) n_state = kvht_pkg::ST_IDLE;
            default: n_state = kvht_pkg::ST_IDLE;
        endcase
        if (i_cfg_we) n_state = kvht_pkg::ST_CLEAR;
    end

    // memory reads, registered
    always_ff @(posedge i_clk) begin
        r_rd_head <= r_heads[(r_state == kvht_pkg::ST_ANY || r_state == kvht_pkg::ST_ANY_W) ?
                             r_scan[BW-1:0] : r_bkt];
        r_rd_key  <= r_keys[(r_state == kvht_pkg::ST_ANY_KEY) ? r_rd_head[NW-1:0]
                                                              : r_cur[NW-1:0]];
        r_rd_val  <= r_vals[r_cur[NW-1:0]];
        r_rd_link <= r_links[(r_state == kvht_pkg::ST_PUT_FREE) ? r_free[NW-1:0]
                                                                : r_cur[NW-1:0]];
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (r_state == kvht_pkg::ST_CLEAR) begin
            r_links[r_clr[NW-1:0]] <= LW'(r_clr) + LW'(1);
            if (r_clr < (NW+1)'(kvht_pkg::MaxBuckets)) r_heads[r_clr[BW-1:0]] <= kvht_pkg::Nil;
        end else if (r_state == kvht_pkg::ST_CHECK && r_kind == kvht_pkg::K_PUT &&
                     r_cur < kvht_pkg::Nil && r_rd_key == r_key && !r_steps[NW]) begin
            r_vals[r_cur[NW-1:0]] <= r_val;
        end else if (r_state == kvht_pkg::ST_PUT_LINK) begin
            r_keys[r_free[NW-1:0]]  <= r_key;
            r_vals[r_free[NW-1:0]]  <= r_val;
            r_links[r_free[NW-1:0]] <= r_rd_head;
            r_heads[r_bkt]          <= r_free;
        end else if (r_state == kvht_pkg::ST_RM_FIX) begin
            if (r_prev < kvht_pkg::Nil) r_links[r_prev[NW-1:0]] <= r_nxt;
            else                        r_heads[r_bkt]          <= r_nxt;
        end else if (r_state == kvht_pkg::ST_RM_LINK) begin
            r_links[r_cur[NW-1:0]] <= r_free;
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt  <= 9'(kvht_pkg::MaxBuckets);
            r_clr   <= '0;
            r_free  <= '0;
            r_total <= '0;
        end else if (i_cfg_we) begin
            r_bcnt  <= w_cfg;
            r_clr   <= '0;
            r_free  <= '0;
            r_total <= '0;
        end else begin
            unique case (r_state)
                kvht_pkg::ST_CLEAR: r_clr <= r_clr + (NW+1)'(1);
                kvht_pkg::ST_IDLE: begin
                    r_kind <= s_in.kind; r_key <= s_in.key; r_val <= s_in.value;
                    r_status <= kvht_pkg::S_OK; r_vout <= '0; r_kout <= '0;
                end
                kvht_pkg::ST_DIV: begin
                    r_bkt  <= w_rem[BW-1:0];
                    r_scan <= '0;
                    if (r_kind == kvht_pkg::K_ANY) r_status <= kvht_pkg::S_EMPTY;
                end
                kvht_pkg::ST_HEAD_W: begin
                    r_cur <= r_rd_head; r_prev <= kvht_pkg::Nil; r_steps <= '0;
                end
                kvht_pkg::ST_NODE_W:
                    if (r_rd_key != r_key) begin
                        r_prev <= r_cur; r_cur <= r_rd_link; r_steps <= r_steps + (NW+1)'(1);
                    end
                kvht_pkg::ST_CHECK:
                    if (r_cur < kvht_pkg::Nil && r_rd_key == r_key && !r_steps[NW]) begin
                        if (r_kind == kvht_pkg::K_GET) r_vout <= r_rd_val;
                        r_nxt <= r_rd_link;
                    end else if (r_kind == kvht_pkg::K_PUT) begin
                        if (r_free >= kvht_pkg::Nil) r_status <= kvht_pkg::S_FULL;
                    end else if (r_kind != kvht_pkg::K_ANY) begin
                        r_status <= kvht_pkg::S_NOT_FOUND;
                    end
                kvht_pkg::ST_PUT_FREE_W: r_nxt <= r_rd_link;
                kvht_pkg::ST_PUT_LINK: begin
                    r_free <= r_nxt; r_total <= r_total + LW'(1);
                end
                kvht_pkg::ST_RM_LINK: begin
                    r_free <= r_cur;
                    if (r_total != '0) r_total <= r_total - LW'(1);
                end
                kvht_pkg::ST_ANY_W: r_scan <= r_scan + 9'd1;
                kvht_pkg::ST_ANY_KEY_W: begin
                    r_kout <= r_rd_key; r_status <= kvht_pkg::S_OK;
                end
                default: ;
            endcase
        end
    end

    // head read during put must see the bucket, read via r_bkt in every state outside the any-key scan
    // rm unlink uses the successor link saved in ST_CHECK, before it is overwritten

    // checks
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != kvht_pkg::ST_IDLE) |-> !s_in.ready) else $error("ready while busy");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= LW'(kvht_pkg::PoolNodes)) else $error("count overflow");
    a_full_only_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && m_out.status == kvht_pkg::S_FULL) |-> r_kind == kvht_pkg::K_PUT)
        else $error("full on non-put");
endmodule

// ----- hdl/kvht_div.sv -----
// ----------------------------------------------------------------------------
// kvht_div
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kvht_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  kvht_pkg::t_div_req       i_req,
    output logic                     o_done,
    output logic [kvht_pkg::CntW-1:0] o_rem
);
    logic [31:0]             r_dvd;
    logic [kvht_pkg::CntW:0] r_rem;
    logic [kvht_pkg::CntW-1:0] r_dsr;
    logic [5:0]              r_cnt;
    logic                    r_busy;
    logic [kvht_pkg::CntW:0] w_shift;

    assign w_shift = {r_rem[kvht_pkg::CntW-1:0], r_dvd[31]};
    assign o_done  = r_busy && (r_cnt == 6'd0);
    assign o_rem   = r_rem[kvht_pkg::CntW-1:0];

    // shift-subtract step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 6'd0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd32;
            r_dvd  <= i_req.mag;
            r_rem  <= '0;
            r_dsr  <= i_req.divisor;
        end else if (r_busy && r_cnt != 6'd0) begin
            r_cnt <= r_cnt - 6'd1;
            r_dvd <= {r_dvd[30:0], 1'b0};
            if (w_shift >= {1'b0, r_dsr}) begin
                r_rem <= w_shift - {1'b0, r_dsr};
            end else begin
                r_rem <= w_shift;
            end
        end else begin
            r_busy <= 1'b0;
        end
    end
endmodule
